>>> design/cnb_pkg.sv
// Shared types and constants for the categorical naive Bayes core.
// Used by cnb_div and categorical_naive_bayes_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cnb_pkg;

  // Item field geometry (fixed by the port widths)
  localparam int NUM_FEATURES = 5;
  localparam int NUM_VALUES   = 3;
  localparam int NUM_CLASSES  = 3;
  localparam int FIELD_W      = 2;
  localparam int FIDX_W       = $clog2(NUM_FEATURES);
  localparam int CIDX_W       = $clog2(NUM_CLASSES);
  localparam int TBL_DEPTH    = NUM_VALUES * NUM_CLASSES * NUM_FEATURES;
  localparam int TBL_AW       = $clog2(TBL_DEPTH);

  // Q0.32 arithmetic
  localparam int QW   = 32;
  localparam int QCNT_W = $clog2(QW);

  // Configuration
  localparam int ESS_W = 4;
  localparam logic [ESS_W-1:0] ESS_RESET = 4'd5;
  localparam logic REG_IDX_ESS = 1'b0;

  typedef enum logic [FIELD_W-1:0] {
    MODE_TRAIN = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TR_RD,
    S_TR_WR,
    S_PRI_GO,
    S_PRI_WAIT,
    S_RD,
    S_EST_GO,
    S_EST_WAIT,
    S_MUL,
    S_CMP,
    S_TIE
  } cnb_state_e;

  // Count table address: (v * classes + c) * features + f
  function automatic logic [TBL_AW-1:0] tbl_index(
    input logic [FIELD_W-1:0] v,
    input logic [CIDX_W-1:0]  c,
    input logic [FIDX_W-1:0]  f
  );
    int idx;
    idx = (int'(v) * NUM_CLASSES + int'(c)) * NUM_FEATURES + int'(f);
    return TBL_AW'(idx);
  endfunction

endpackage

`default_nettype wire

>>> design/cnb_div.sv
// Bit-serial restoring divider giving a truncated Q0.32 quotient.
// Depends on cnb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cnb_div #(
  parameter int W = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [W-1:0]         num_i,
  input  logic [W-1:0]         den_i,
  output logic                 done_o,
  output logic [cnb_pkg::QW-1:0] quo_o
);
  import cnb_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [QCNT_W-1:0] step_q;
  logic [W-1:0]      rem_q;
  logic [W-1:0]      den_q;
  logic [QW-1:0]     quo_q;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       ge;
  logic       den_zero;
  logic       num_big;

  assign shifted  = {rem_q, 1'b0};
  assign diff     = shifted - {1'b0, den_q};
  assign ge       = shifted >= {1'b0, den_q};
  assign den_zero = (den_i == '0);
  assign num_big  = (num_i >= den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= '0;
        if (den_zero || num_big) begin
          // zero divisor or quotient >= 1: answered at once
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == QCNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      if (den_zero) begin
        quo_q <= '0;
      end else if (num_big) begin
        quo_q <= '1;
      end else begin
        quo_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> design/categorical_naive_bayes_core.sv
// Categorical naive Bayes classifier core: count tables, m-estimate scoring.
// Depends on cnb_pkg and cnb_div.
//
// Channel   Dir  Handshake              Word
// cfg       in   psel/penable/pwrite    equivalent_sample_size at byte 0
// in        in   in_valid_i/in_ready_o  mode, feature_0..4, class_label
// out       out  out_valid_o/out_ready_i predicted_class, tie_mask, winning_score
//
// One item at a time; in_ready_o is high only while the sequencer idles.
// Train: read-modify-write of five table entries, one port.
// Clear: zeroes the valid bits and class/row counters at once.
// Query: eighteen Q0.32 quotients (three priors, fifteen estimates) go
//   through one bit-serial divider at one bit per cycle (answered at once
//   when the divisor is zero or the quotient saturates); each estimate is
//   then multiplied into the running score on the shared 32x32 multiplier.
// The result waits in an output register, so a new word is taken while it
// is stalled; a second query result waits in the tie stage until it drains.
// Reset leaves all counts zero and w = 5; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module categorical_naive_bayes_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cnb_pkg::FIELD_W-1:0]  mode_i,
  input  logic [cnb_pkg::FIELD_W-1:0]  feature_0_i,
  input  logic [cnb_pkg::FIELD_W-1:0]  feature_1_i,
  input  logic [cnb_pkg::FIELD_W-1:0]  feature_2_i,
  input  logic [cnb_pkg::FIELD_W-1:0]  feature_3_i,
  input  logic [cnb_pkg::FIELD_W-1:0]  feature_4_i,
  input  logic [cnb_pkg::FIELD_W-1:0]  class_label_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cnb_pkg::CIDX_W-1:0]   predicted_class_o,
  output logic [cnb_pkg::NUM_CLASSES-1:0] tie_mask_o,
  output logic [cnb_pkg::QW-1:0]       winning_score_o
);
  import cnb_pkg::*;

  // divider operand width: 3*(count + w) needs two extra bits plus carry
  localparam int OPW = COUNT_WIDTH + 3;

  cnb_state_e state_q, state_d;

  // configuration
  logic [ESS_W-1:0] ess_q;
  logic             cfg_we;

  // latched input word
  logic [FIELD_W-1:0] mode_q;
  logic [FIELD_W-1:0] feat_q [NUM_FEATURES];
  logic [FIELD_W-1:0] lab_q;

  // loop counters
  logic [FIDX_W-1:0] f_q;
  logic [CIDX_W-1:0] c_q;
  logic              last_f;
  logic              last_c;

  // count storage
  logic [COUNT_WIDTH-1:0] mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0]   vld_q;
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   rd_vld_q;
  logic [COUNT_WIDTH-1:0] cls_cnt_q [NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] tot_q;

  // scoring datapath
  logic [QW-1:0]   s_q;
  logic [QW-1:0]   est_q;
  logic [QW-1:0]   sc_q [NUM_CLASSES];
  logic [QW-1:0]   best_q;
  logic [CIDX_W-1:0] win_q;
  logic [2*QW-1:0] prod;

  // output register
  logic                   out_valid_q;
  logic [CIDX_W-1:0]      pred_q;
  logic [NUM_CLASSES-1:0] mask_q;
  logic [QW-1:0]          score_q;

  // sequencer outputs
  logic in_ready;
  logic div_start;
  logic mem_re;
  logic mem_we;
  logic out_load;

  // misc combinational
  logic                   row_ok;
  logic [FIELD_W-1:0]     cur_v;
  logic                   cur_in_range;
  logic [CIDX_W-1:0]      tbl_cls;
  logic [TBL_AW-1:0]      tbl_addr;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CIDX_W-1:0]      cls_idx;
  logic [COUNT_WIDTH-1:0] cls_cnt;
  logic [OPW-1:0]         est_num;
  logic [OPW-1:0]         est_den;
  logic [OPW-1:0]         cls_plus_w;
  logic [OPW-1:0]         div_num;
  logic [OPW-1:0]         div_den;
  logic                   div_done;
  logic [QW-1:0]          div_quo;
  logic [NUM_CLASSES-1:0] tie_mask;

  assign last_f = (f_q == FIDX_W'(NUM_FEATURES - 1));
  assign last_c = (c_q == CIDX_W'(NUM_CLASSES - 1));

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_IDX_ESS);
  assign prdata = (paddr[2] == REG_IDX_ESS) ? {{(32 - ESS_W){1'b0}}, ess_q} : 32'd0;

  // ---------------------------------------------------------------- decode
  always_comb begin
    row_ok = (lab_q < FIELD_W'(NUM_CLASSES));
    for (int i = 0; i < NUM_FEATURES; i++) begin
      if (feat_q[i] >= FIELD_W'(NUM_VALUES)) begin
        row_ok = 1'b0;
      end
    end
  end

  // table address for the current feature; an out-of-range query value
  // reads as a zero count
  assign cur_v        = feat_q[f_q];
  assign cur_in_range = (cur_v < FIELD_W'(NUM_VALUES));
  assign tbl_cls      = (state_q == S_TR_RD || state_q == S_TR_WR) ? lab_q[CIDX_W-1:0] : c_q;
  assign tbl_addr     = tbl_index(cur_in_range ? cur_v : '0, tbl_cls, f_q);

  assign cnt     = rd_vld_q ? rd_data_q : '0;
  assign cnt_inc = (cnt == '1) ? cnt : cnt + 1'b1;

  assign cls_idx = (state_q == S_TR_WR) ? lab_q[CIDX_W-1:0] : c_q;
  assign cls_cnt = cls_cnt_q[cls_idx];

  // m-estimate operands: (3*cnt + w) / (3*(class count + w))
  assign cls_plus_w = OPW'(cls_cnt) + OPW'(ess_q);
  assign est_num    = (OPW'(cnt) << 1) + OPW'(cnt) + OPW'(ess_q);
  assign est_den    = (cls_plus_w << 1) + cls_plus_w;

  assign div_num = (state_q == S_PRI_GO) ? OPW'(cls_cnt) : est_num;
  assign div_den = (state_q == S_PRI_GO) ? OPW'(tot_q) : est_den;

  assign prod = s_q * est_q;

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      tie_mask[i] = (sc_q[i] == best_q);
    end
  end

  cnb_div #(
    .W (OPW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    div_start = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (mode_q)
          MODE_TRAIN: state_d = row_ok ? S_TR_RD : S_IDLE;
          MODE_QUERY: state_d = S_PRI_GO;
          MODE_CLEAR: state_d = S_IDLE;
          default:    state_d = S_IDLE;
        endcase
      end
      S_TR_RD: begin
        mem_re  = 1'b1;
        state_d = S_TR_WR;
      end
      S_TR_WR: begin
        mem_we  = 1'b1;
        state_d = last_f ? S_IDLE : S_TR_RD;
      end
      S_PRI_GO: begin
        div_start = 1'b1;
        state_d   = S_PRI_WAIT;
      end
      S_PRI_WAIT: begin
        if (div_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_EST_GO;
      end
      S_EST_GO: begin
        div_start = 1'b1;
        state_d   = S_EST_WAIT;
      end
      S_EST_WAIT: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = last_f ? S_CMP : S_RD;
      end
      S_CMP: begin
        state_d = last_c ? S_TIE : S_PRI_GO;
      end
      S_TIE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ess_q       <= ESS_RESET;
      f_q         <= '0;
      c_q         <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cls_cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        ess_q <= pwdata[ESS_W-1:0];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (mem_re) begin
        rd_vld_q <= cur_in_range && vld_q[tbl_addr];
      end

      unique case (state_q)
        S_DECODE: begin
          f_q <= '0;
          c_q <= '0;
          if (mode_q == MODE_CLEAR) begin
            vld_q <= '0;
            tot_q <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
              cls_cnt_q[i] <= '0;
            end
          end
        end
        S_TR_WR: begin
          vld_q[tbl_addr] <= 1'b1;
          f_q             <= f_q + 1'b1;
          if (last_f) begin
            cls_cnt_q[cls_idx] <= (cls_cnt == '1) ? cls_cnt : cls_cnt + 1'b1;
            tot_q              <= (tot_q == '1) ? tot_q : tot_q + 1'b1;
          end
        end
        S_PRI_WAIT: begin
          f_q <= '0;
        end
        S_MUL: begin
          if (!last_f) begin
            f_q <= f_q + 1'b1;
          end
        end
        S_CMP: begin
          if (!last_c) begin
            c_q <= c_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- count table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tbl_addr] <= cnt_inc;
    end
    if (mem_re) begin
      rd_data_q <= mem[tbl_addr];
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      mode_q    <= mode_i;
      feat_q[0] <= feature_0_i;
      feat_q[1] <= feature_1_i;
      feat_q[2] <= feature_2_i;
      feat_q[3] <= feature_3_i;
      feat_q[4] <= feature_4_i;
      lab_q     <= class_label_i;
    end

    unique case (state_q)
      S_PRI_WAIT: begin
        if (div_done) begin
          s_q <= div_quo;   // prior
        end
      end
      S_EST_WAIT: begin
        if (div_done) begin
          est_q <= div_quo;
        end
      end
      S_MUL: begin
        s_q <= prod[2*QW-1:QW];
      end
      S_CMP: begin
        sc_q[c_q] <= s_q;
        // strict compare keeps the lowest index on a tie
        if (c_q == '0 || s_q > best_q) begin
          best_q <= s_q;
          win_q  <= c_q;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      pred_q  <= win_q;
      mask_q  <= tie_mask;
      score_q <= best_q;
    end
  end

  assign in_ready_o        = in_ready;
  assign out_valid_o       = out_valid_q;
  assign predicted_class_o = pred_q;
  assign tie_mask_o        = mask_q;
  assign winning_score_o   = score_q;

`ifndef SYNTHESIS
  // divider answers only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_PRI_WAIT || state_q == S_EST_WAIT))
    else $error("divider done outside a wait state");

  // every counted row adds to the total, so no class count passes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_cnt_q[0] <= tot_q) && (cls_cnt_q[1] <= tot_q) && (cls_cnt_q[2] <= tot_q))
    else $error("class count exceeds total rows");

  // an accepted word is decoded on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted word not decoded");

  // a finished query always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TIE && (!out_valid_o || out_ready_i)) |=> out_valid_o)
    else $error("query result lost");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for categorical_naive_bayes_core: directed table, then random train/query/clear traffic.
// Depends on cnb_pkg and the core RTL; expected results come from a local predictor.
`timescale 1ns / 1ps

module tb;
  import cnb_pkg::*;

  localparam int CNT_W       = 16;                      // matches the core's default
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int REST_CYCLES = 800;
  localparam int PHASE_WORDS = 667;                     // three phases, ~2000 words in all
  localparam logic [FIELD_W-1:0] MODE_SPARE = 2'd3;     // unused mode, core drops it

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // One input word as the core sees it; feat[0] is feature_0.
  typedef struct packed {
    logic [FIELD_W-1:0]                      mode;
    logic [NUM_FEATURES-1:0][FIELD_W-1:0]    feat;
    logic [FIELD_W-1:0]                      label;
  } word_t;

  // One classification result.
  typedef struct packed {
    logic [CIDX_W-1:0]      cls;
    logic [NUM_CLASSES-1:0] mask;
    logic [QW-1:0]          score;
  } verdict_t;

  // Directed row: a word (optionally with a hand-typed result) or a weight write.
  typedef struct packed {
    row_kind_e                            kind;
    logic [FIELD_W-1:0]                   mode;
    logic [NUM_FEATURES-1:0][FIELD_W-1:0] feat;   // written {f4, f3, f2, f1, f0}
    logic [FIELD_W-1:0]                   label;
    logic                                 typed;
    verdict_t                             want;
    logic [ESS_W-1:0]                     ess;
  } plan_row_t;

  localparam int PLAN_ROWS = 27;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // empty table: every prior is zero, class 0 wins, all tie
    '{ROW_WORD, MODE_QUERY, {5{2'd0}}, 2'd0, 1'b1, '{2'd0, 3'b111, 32'h0}, 4'd0},
    '{ROW_WORD, MODE_QUERY, {5{2'd3}}, 2'd3, 1'b1, '{2'd0, 3'b111, 32'h0}, 4'd0},
    // a few rows, then rows the core must drop
    '{ROW_WORD, MODE_TRAIN, {5{2'd0}}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_TRAIN, {5{2'd2}}, 2'd2, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_TRAIN, {2'd2, 2'd1, 2'd0, 2'd2, 2'd1}, 2'd1, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_TRAIN, {5{2'd1}}, 2'd3, 1'b0, '0, 4'd0},                   // bad label
    '{ROW_WORD, MODE_TRAIN, {2'd0, 2'd0, 2'd0, 2'd0, 2'd3}, 2'd0, 1'b0, '0, 4'd0}, // bad value
    '{ROW_WORD, MODE_SPARE, {5{2'd1}}, 2'd1, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {5{2'd0}}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {5{2'd2}}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {2'd3, 2'd1, 2'd3, 2'd1, 2'd3}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {2'd2, 2'd1, 2'd0, 2'd2, 2'd1}, 2'd3, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_TRAIN, {2'd1, 2'd0, 2'd2, 2'd1, 2'd0}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_CLEAR, {5{2'd0}}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {5{2'd1}}, 2'd0, 1'b1, '{2'd0, 3'b111, 32'h0}, 4'd0},
    // w = 0: zero divisors for untrained classes, saturating quotients for class 2
    '{ROW_CFG,  MODE_TRAIN, {5{2'd0}}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_TRAIN, {5{2'd1}}, 2'd2, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {5{2'd1}}, 2'd0, 1'b1, '{2'd2, 3'b100, 32'hFFFF_FFFA}, 4'd0},
    '{ROW_WORD, MODE_QUERY, {2'd1, 2'd1, 2'd1, 2'd1, 2'd3}, 2'd0, 1'b1,
      '{2'd0, 3'b111, 32'h0}, 4'd0},
    '{ROW_WORD, MODE_QUERY, {2'd1, 2'd1, 2'd1, 2'd1, 2'd0}, 2'd0, 1'b0, '0, 4'd0},
    // w = 15
    '{ROW_CFG,  MODE_TRAIN, {5{2'd0}}, 2'd0, 1'b0, '0, 4'd15},
    '{ROW_WORD, MODE_TRAIN, {2'd0, 2'd2, 2'd1, 2'd0, 2'd2}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {2'd0, 2'd2, 2'd1, 2'd0, 2'd2}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {5{2'd3}}, 2'd0, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_CLEAR, {5{2'd3}}, 2'd3, 1'b0, '0, 4'd0},
    '{ROW_WORD, MODE_QUERY, {5{2'd2}}, 2'd0, 1'b1, '{2'd0, 3'b111, 32'h0}, 4'd0},
    '{ROW_CFG,  MODE_TRAIN, {5{2'd0}}, 2'd0, 1'b0, '0, 4'd5}
  };

  // ---------------------------------------------------------------------------
  // DUT connections
  // ---------------------------------------------------------------------------
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel, penable, pwrite, pready;
  logic [2:0]             paddr;
  logic [31:0]            pwdata, prdata;
  logic                   in_valid_i, in_ready_o;
  logic [FIELD_W-1:0]     mode_i, class_label_i;
  logic [FIELD_W-1:0]     feature_0_i, feature_1_i, feature_2_i, feature_3_i, feature_4_i;
  logic                   out_valid_o, out_ready_i;
  logic [CIDX_W-1:0]      predicted_class_o;
  logic [NUM_CLASSES-1:0] tie_mask_o;
  logic [QW-1:0]          winning_score_o;

  categorical_naive_bayes_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .feature_0_i       (feature_0_i),
    .feature_1_i       (feature_1_i),
    .feature_2_i       (feature_2_i),
    .feature_3_i       (feature_3_i),
    .feature_4_i       (feature_4_i),
    .class_label_i     (class_label_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .predicted_class_o (predicted_class_o),
    .tie_mask_o        (tie_mask_o),
    .winning_score_o   (winning_score_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the count tables and the m-estimate weight
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] vc_count [NUM_FEATURES][NUM_VALUES][NUM_CLASSES];
  logic [CNT_W-1:0] cls_count [NUM_CLASSES];
  logic [CNT_W-1:0] row_count;
  logic [ESS_W-1:0] ess_weight;

  verdict_t expected_verdicts [$];
  int       mismatches  = 0;
  int       tx_idle_pct = 0;     // chance in 100 that the sender idles a cycle
  int       rx_idle_pct = 0;     // chance in 100 that the receiver stalls a cycle

  function automatic void wipe_counts();
    foreach (vc_count[f, v, c]) vc_count[f][v][c] = '0;
    foreach (cls_count[c]) cls_count[c] = '0;
    row_count = '0;
  endfunction

  function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] x);
    return (x == CNT_MAX) ? x : x + 1'b1;
  endfunction

  // floor(num / den) in Q0.32; zero divisor gives zero, one or more saturates
  function automatic logic [QW-1:0] q32_quot(input logic [63:0] num, input logic [63:0] den);
    if (den == 0) return '0;
    if (num >= den) return '1;
    return QW'((num << QW) / den);
  endfunction

  // Words the core throws away without touching any state (spare mode, broken train rows)
  function automatic bit is_dropped(input word_t w);
    if (w.mode == MODE_SPARE) return 1'b1;
    if (w.mode != MODE_TRAIN) return 1'b0;
    if (w.label >= NUM_CLASSES) return 1'b1;
    for (int f = 0; f < NUM_FEATURES; f++)
      if (w.feat[f] >= NUM_VALUES) return 1'b1;
    return 1'b0;
  endfunction

  // Train updates the tables, clear wipes them, query scores every class.
  // Returns 1 when the word produces a result.
  function automatic bit tally_or_score(input word_t w, output verdict_t v);
    logic [63:0]      s, est, cnt, wt;
    logic [QW-1:0]    score [NUM_CLASSES];
    logic [QW-1:0]    top;
    int               win;
    v  = '0;
    wt = 64'(ess_weight);
    if (is_dropped(w)) return 1'b0;
    case (w.mode)
      MODE_TRAIN: begin
        for (int f = 0; f < NUM_FEATURES; f++)
          vc_count[f][w.feat[f]][w.label] = sat_up(vc_count[f][w.feat[f]][w.label]);
        cls_count[w.label] = sat_up(cls_count[w.label]);
        row_count = sat_up(row_count);
        return 1'b0;
      end
      MODE_CLEAR: begin
        wipe_counts();
        return 1'b0;
      end
      default: begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          s = 64'(q32_quot(64'(cls_count[c]), 64'(row_count)));   // prior
          for (int f = 0; f < NUM_FEATURES; f++) begin
            cnt = 64'd0;
            if (w.feat[f] < NUM_VALUES) cnt = 64'(vc_count[f][w.feat[f]][c]);
            // (count + w/V) / (class + w), scaled by V to stay exact
            est = 64'(q32_quot(NUM_VALUES * cnt + wt, NUM_VALUES * (64'(cls_count[c]) + wt)));
            s   = (s * est) >> QW;
          end
          score[c] = s[QW-1:0];
        end
        top = score[0];
        win = 0;
        for (int c = 1; c < NUM_CLASSES; c++)
          if (score[c] > top) begin
            top = score[c];
            win = c;
          end
        for (int c = 0; c < NUM_CLASSES; c++) v.mask[c] = (score[c] == top);
        v.cls   = CIDX_W'(win);
        v.score = top;
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random idle gap, then hold the word until in_ready_o takes it
  // ---------------------------------------------------------------------------
  task automatic send_word(input word_t w, input bit typed, input verdict_t fixed);
    int       gap;
    verdict_t v;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= w.mode;
    feature_0_i   <= w.feat[0];
    feature_1_i   <= w.feat[1];
    feature_2_i   <= w.feat[2];
    feature_3_i   <= w.feat[3];
    feature_4_i   <= w.feat[4];
    class_label_i <= w.label;
    do @(posedge clk_i); while (!in_ready_o);
    // word accepted at this edge: advance the predictor in the same order
    if (tally_or_score(w, v)) expected_verdicts.push_back(typed ? fixed : v);
  endtask

  // Weight register write: setup cycle, then access cycle until pready
  task automatic write_ess(input logic [ESS_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(REG_IDX_ESS));
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ess_weight = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // All results in, then give any trailing train/clear time to finish
  task automatic drain_and_rest();
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (REST_CYCLES) @(posedge clk_i);
  endtask

  // Mostly batches of good training rows followed by queries that reuse
  // their feature values; sprinkled with clears, broken rows and stray words.
  task automatic run_traffic(input int quota);
    int    taken;
    int    n_train;
    int    n_query;
    word_t w;
    word_t rows [$];
    taken = 0;
    while (taken < quota) begin
      rows.delete();
      if ($urandom_range(99) < 8) begin
        w = 14'($urandom);                      // anything at all, incl. spare mode
        send_word(w, 1'b0, '0);
        if (!is_dropped(w)) taken++;
        continue;
      end
      if ($urandom_range(99) < 10) begin
        w.mode  = MODE_CLEAR;
        w.feat  = 10'($urandom);
        w.label = 2'($urandom);
        send_word(w, 1'b0, '0);
        taken++;
      end
      n_train = $urandom_range(1, 10);
      repeat (n_train) begin
        w.mode = MODE_TRAIN;
        for (int f = 0; f < NUM_FEATURES; f++) w.feat[f] = 2'($urandom_range(0, 2));
        w.label = 2'($urandom_range(0, 2));
        if ($urandom_range(19) == 0) begin     // broken row
          if ($urandom_range(1)) w.label = 2'd3;
          else w.feat[$urandom_range(0, NUM_FEATURES - 1)] = 2'd3;
        end
        send_word(w, 1'b0, '0);
        if (!is_dropped(w)) begin
          taken++;
          rows.push_back(w);
        end
      end
      n_query = $urandom_range(1, 3);
      repeat (n_query) begin
        w.mode = MODE_QUERY;
        if (rows.size() > 0 && $urandom_range(9) < 7)
          w.feat = rows[$urandom_range(0, rows.size() - 1)].feat;
        else
          for (int f = 0; f < NUM_FEATURES; f++) w.feat[f] = 2'($urandom_range(0, 2));
        if ($urandom_range(19) == 0) w.feat[$urandom_range(0, NUM_FEATURES - 1)] = 2'd3;
        w.label = 2'($urandom);
        send_word(w, 1'b0, '0);
        taken++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls on out_ready_i; every taken result is checked
  // against the oldest expectation. Values read here are the pre-edge ones.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("result word with nothing expected: class %0d mask %b score %h",
               predicted_class_o, tie_mask_o, winning_score_o);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (predicted_class_o !== want.cls) begin
          $error("predicted_class: expected %0d, got %0d", want.cls, predicted_class_o);
          mismatches++;
        end
        if (tie_mask_o !== want.mask) begin
          $error("tie_mask: expected %b, got %b", want.mask, tie_mask_o);
          mismatches++;
        end
        if (winning_score_o !== want.score) begin
          $error("winning_score: expected %h, got %h", want.score, winning_score_o);
          mismatches++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int   tx_plan [3];
    int   rx_plan [3];
    word_t w;
    tx_plan = '{23, 86, 0};
    rx_plan = '{86, 23, 0};
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    mode_i        <= MODE_TRAIN;
    feature_0_i   <= '0;
    feature_1_i   <= '0;
    feature_2_i   <= '0;
    feature_3_i   <= '0;
    feature_4_i   <= '0;
    class_label_i <= '0;
    out_ready_i   <= 1'b0;
    wipe_counts();
    ess_weight = ESS_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, light idling on both sides
    tx_idle_pct = 15;
    rx_idle_pct = 30;
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        // the last word is already taken; stop offering it
        in_valid_i <= 1'b0;
        drain_and_rest();
        write_ess(PLAN[i].ess);
      end else begin
        w.mode  = PLAN[i].mode;
        w.feat  = PLAN[i].feat;
        w.label = PLAN[i].label;
        send_word(w, PLAN[i].typed, PLAN[i].want);
      end
    end

    // random phases: slow receiver, then slow sender, then full rate
    for (int p = 0; p < 3; p++) begin
      drain_and_rest();
      write_ess((p == 1) ? 4'd15 : 4'($urandom_range(0, 15)));
      tx_idle_pct = tx_plan[p];
      rx_idle_pct = rx_plan[p];
      run_traffic(PHASE_WORDS);
      in_valid_i <= 1'b0;
    end

    drain_and_rest();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run
  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
